>>> rtl/rfca_pkg.sv
package rfca_pkg;

    typedef enum logic [2:0] {
        REQ_CARD_READ    = 3'd0,
        REQ_START_ENROLL = 3'd1,
        REQ_REVOKE       = 3'd2,
        REQ_TICK         = 3'd3,
        REQ_SET_STATE    = 3'd4
    } req_t;

    typedef enum logic [2:0] {
        STS_OK           = 3'd0,
        STS_GRANTED      = 3'd1,
        STS_DENIED       = 3'd2,
        STS_ENROLLED     = 3'd3,
        STS_NOT_DISARMED = 3'd4,
        STS_TABLE_FULL   = 3'd5,
        STS_BAD_INDEX    = 3'd6,
        STS_TIMEOUT      = 3'd7
    } status_t;

    localparam logic [2:0] MODE_DISARMED = 3'd0;
    localparam logic [2:0] MODE_ARMING   = 3'd1;
    localparam logic [2:0] MODE_ALARM    = 3'd5;
    localparam logic [2:0] MODE_ENROLL   = 3'd6;

    localparam int unsigned TIMER_BITS    = 32;
    localparam logic [TIMER_BITS-1:0] TIMEOUT_RESET = 32'd30000;

    typedef struct packed {
        logic latch;
        logic start;
        logic step;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic need_scan;
        logic need_shift;
        logic scan_done;
        logic shift_done;
        logic out_free;
    } sts_t;

endpackage

>>> rtl/rfca_ctrl.sv
module rfca_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  rfca_pkg::sts_t sts,
    output rfca_pkg::cmd_t cmd
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_DECIDE = 5'b00010,
        S_SCAN   = 5'b00100,
        S_SHIFT  = 5'b01000,
        S_FINISH = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                s_tready  = 1'b1;
                cmd.latch = s_tvalid;
                if (s_tvalid)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (sts.need_scan)
                begin
                    cmd.start  = 1'b1;
                    state_next = S_SCAN;
                end
                else if (sts.need_shift)
                begin
                    cmd.start  = 1'b1;
                    state_next = S_SHIFT;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_SCAN:
            begin
                cmd.step = 1'b1;
                if (sts.scan_done)
                begin
                    state_next = S_FINISH;
                end
            end
            S_SHIFT:
            begin
                cmd.step = 1'b1;
                if (sts.shift_done)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> rtl/rfca_datapath.sv
module rfca_datapath
#(
    parameter int TABLE_DEPTH = 16,
    parameter int CODE_BITS   = 32
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic [47:0]    s_tdata,
    input  logic [2:0]     s_tuser,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [23:0]    m_tdata,
    output logic [2:0]     m_tuser,
    input  logic           cfg_wr_en,
    input  logic [31:0]    cfg_wr_data,
    input  rfca_pkg::cmd_t cmd,
    output rfca_pkg::sts_t sts
);

    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int XW = (CW > 8) ? CW : 8;
    localparam int KW = (CODE_BITS < 32) ? CODE_BITS : 32;

    logic [CODE_BITS-1:0] mem [TABLE_DEPTH];

    rfca_pkg::req_t       req_reg;
    logic [CODE_BITS-1:0] code_reg;
    logic [7:0]           idx_reg;
    logic [2:0]           lvl_reg;

    logic [CW-1:0]        count_reg;
    logic [CW-1:0]        count_next;
    logic [2:0]           mode_reg;
    logic [2:0]           mode_next;
    logic [rfca_pkg::TIMER_BITS-1:0] timer_reg;
    logic [rfca_pkg::TIMER_BITS-1:0] timer_next;
    logic [rfca_pkg::TIMER_BITS-1:0] timer_inc;
    logic [rfca_pkg::TIMER_BITS-1:0] timeout_reg;

    logic [CW-1:0]        ptr_reg;
    logic                 vld_reg;
    logic [CW-1:0]        tag_reg;
    logic [CODE_BITS-1:0] rd_data_reg;
    logic                 found_reg;
    logic [AW-1:0]        match_reg;

    logic                 m_tvalid_reg;
    logic [23:0]          m_tdata_reg;
    logic [2:0]           m_tuser_reg;

    logic                 is_revoke;
    logic                 idx_ok;
    logic                 full;
    logic                 hit;
    logic                 scan_end;
    logic                 more;
    logic                 app_we;
    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic [CODE_BITS-1:0] mem_wdata;

    rfca_pkg::status_t    status;
    logic                 cvalid;
    logic [2:0]           cstate;
    logic                 swoff;

    assign is_revoke = (req_reg == rfca_pkg::REQ_REVOKE);
    assign idx_ok    = XW'(idx_reg) < XW'(count_reg);
    assign full      = count_reg >= CW'(TABLE_DEPTH);
    assign hit       = vld_reg && (rd_data_reg == code_reg);
    assign scan_end  = vld_reg && (tag_reg == count_reg - CW'(1));
    assign more      = ptr_reg < count_reg;
    assign timer_inc = (&timer_reg) ? timer_reg : timer_reg + 32'd1;

    assign sts.need_scan  = (req_reg == rfca_pkg::REQ_CARD_READ) &&
                            (mode_reg != rfca_pkg::MODE_ENROLL) && (count_reg != '0);
    assign sts.need_shift = is_revoke && idx_ok;
    assign sts.scan_done  = hit || scan_end;
    assign sts.shift_done = !vld_reg && !more;
    assign sts.out_free   = !m_tvalid_reg || m_tready;

    always_comb
    begin
        mode_next  = mode_reg;
        count_next = count_reg;
        timer_next = timer_reg;
        status     = rfca_pkg::STS_OK;
        cvalid     = 1'b0;
        cstate     = rfca_pkg::MODE_DISARMED;
        swoff      = 1'b0;
        app_we     = 1'b0;
        case (req_reg)
            rfca_pkg::REQ_CARD_READ:
            begin
                if (mode_reg == rfca_pkg::MODE_ENROLL)
                begin
                    if (!full)
                    begin
                        app_we     = 1'b1;
                        count_next = count_reg + CW'(1);
                        status     = rfca_pkg::STS_ENROLLED;
                    end
                    else
                    begin
                        status = rfca_pkg::STS_TABLE_FULL;
                    end
                    mode_next = rfca_pkg::MODE_DISARMED;
                end
                else if (found_reg)
                begin
                    status = rfca_pkg::STS_GRANTED;
                    cvalid = 1'b1;
                    if (mode_reg == rfca_pkg::MODE_DISARMED)
                    begin
                        cstate = rfca_pkg::MODE_ARMING;
                        swoff  = 1'b1;
                    end
                end
                else
                begin
                    status = rfca_pkg::STS_DENIED;
                end
            end
            rfca_pkg::REQ_START_ENROLL:
            begin
                if (mode_reg != rfca_pkg::MODE_DISARMED)
                begin
                    status = rfca_pkg::STS_NOT_DISARMED;
                end
                else if (full)
                begin
                    status = rfca_pkg::STS_TABLE_FULL;
                end
                else
                begin
                    mode_next  = rfca_pkg::MODE_ENROLL;
                    timer_next = '0;
                end
            end
            rfca_pkg::REQ_REVOKE:
            begin
                if (!idx_ok)
                begin
                    status = rfca_pkg::STS_BAD_INDEX;
                end
                else
                begin
                    count_next = count_reg - CW'(1);
                end
            end
            rfca_pkg::REQ_TICK:
            begin
                if (mode_reg == rfca_pkg::MODE_ENROLL)
                begin
                    timer_next = timer_inc;
                    if (timer_inc >= timeout_reg)
                    begin
                        mode_next = rfca_pkg::MODE_DISARMED;
                        status    = rfca_pkg::STS_TIMEOUT;
                    end
                end
            end
            rfca_pkg::REQ_SET_STATE:
            begin
                if ((mode_reg != rfca_pkg::MODE_ENROLL) && (lvl_reg <= rfca_pkg::MODE_ALARM))
                begin
                    mode_next = lvl_reg;
                end
            end
            default:
            begin
                status = rfca_pkg::STS_OK;
            end
        endcase
    end

    assign mem_we    = (cmd.step && is_revoke && vld_reg) || (cmd.commit && app_we);
    assign mem_waddr = cmd.commit ? count_reg[AW-1:0] : tag_reg[AW-1:0];
    assign mem_wdata = cmd.commit ? code_reg : rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.step && more)
        begin
            rd_data_reg <= mem[ptr_reg[AW-1:0]];
            tag_reg     <= is_revoke ? ptr_reg - CW'(1) : ptr_reg;
        end
        if (cmd.latch)
        begin
            code_reg <= CODE_BITS'(s_tdata[KW-1:0]);
            idx_reg  <= s_tdata[39:32];
            lvl_reg  <= s_tdata[42:40];
        end
        if (cmd.step && hit && !found_reg)
        begin
            match_reg <= tag_reg[AW-1:0];
        end
        if (cmd.commit)
        begin
            m_tuser_reg <= status;
            m_tdata_reg <= {7'd0,
                            found_reg ? 4'(match_reg) : 4'd0,
                            5'(count_next),
                            swoff,
                            cstate,
                            cvalid,
                            mode_next};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_reg      <= rfca_pkg::REQ_CARD_READ;
            count_reg    <= '0;
            mode_reg     <= rfca_pkg::MODE_DISARMED;
            timer_reg    <= '0;
            timeout_reg  <= rfca_pkg::TIMEOUT_RESET;
            ptr_reg      <= '0;
            vld_reg      <= 1'b0;
            found_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                timeout_reg <= cfg_wr_data;
            end
            if (cmd.latch)
            begin
                req_reg   <= rfca_pkg::req_t'(s_tuser);
                found_reg <= 1'b0;
            end
            if (cmd.start)
            begin
                ptr_reg <= is_revoke ? CW'(XW'(idx_reg) + XW'(1)) : '0;
                vld_reg <= 1'b0;
            end
            else if (cmd.step)
            begin
                if (more)
                begin
                    ptr_reg <= ptr_reg + CW'(1);
                    vld_reg <= 1'b1;
                end
                else
                begin
                    vld_reg <= 1'b0;
                end
                if (hit && !is_revoke)
                begin
                    found_reg <= 1'b1;
                end
            end
            if (cmd.commit)
            begin
                mode_reg     <= mode_next;
                count_reg    <= count_next;
                timer_reg    <= timer_next;
                vld_reg      <= 1'b0;
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

>>> rtl/rfid_credential_table_arming_control.sv
// Keeps a compacted table of card codes in a small memory with one read and one write port,
// beside a local alarm mode, and answers every request with exactly one result. A request is
// taken when the block is idle; tick, set_state and start_enroll requests, and an enrolling
// card read, go straight from the decide state to the finish state without walking the table.
// A lookup card read walks the table one entry per cycle and stops at the first match; a
// revoke shifts the later entries down one per cycle. A finished result waits in an output
// register, and the next request may be taken while it waits. The table needs no clearing
// after reset.
module rfid_credential_table_arming_control
#(
    parameter int TABLE_DEPTH = 16,
    parameter int CODE_BITS   = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,     // card_code[31:0], entry_index[39:32], new_state[42:40]
    input  logic [2:0]  s_tuser,     // req_type[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,     // alarm_state[2:0], command_valid[3], command_state[6:4],
                                     // switch_off_alarm[7], entry_count[12:8],
                                     // matched_index[16:13]
    output logic [2:0]  m_tuser,     // status[2:0]
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data  // enroll_timeout_ticks
);

    rfca_pkg::cmd_t cmd;
    rfca_pkg::sts_t sts;

    rfca_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    rfca_datapath
    #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .CODE_BITS   (CODE_BITS)
    )
    u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .sts         (sts)
    );

`ifndef NO_ASSERTIONS
    a_commit_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> sts.out_free)
        else $error("Result committed while the output register was still full.");

    a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("A second request was taken before the first one finished.");

    a_step_not_commit: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.step && cmd.commit) && !(cmd.start && cmd.commit))
        else $error("Table walk overlapped with a result commit.");

    a_no_grant_enrolling: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == rfca_pkg::STS_GRANTED) |->
            (m_tdata[2:0] != rfca_pkg::MODE_ENROLL))
        else $error("A card was granted while in enrolling mode.");
`endif

endmodule

>>> dv/tb_rfid_credential_table_arming_control.sv
`timescale 1ns / 100ps

module tb_rfid_credential_table_arming_control;

    localparam int unsigned DEPTH       = 16;
    localparam int unsigned STUCK_LIMIT = 5000;
    localparam int unsigned DRAIN       = 40;

    typedef struct {
        logic [2:0]  req;
        logic [31:0] code;
        logic [7:0]  idx;
        logic [2:0]  lvl;
    } request_t;

    typedef struct {
        rfca_pkg::status_t status;
        logic [2:0]  alarm;
        logic        cmd_valid;
        logic [2:0]  cmd_level;
        logic        siren_off;
        logic [4:0]  count;
        logic [3:0]  match;
    } reply_t;

    class credential_scoreboard;
        logic [31:0]  codes [DEPTH];
        int unsigned  stored;
        logic [2:0]   mode;
        logic [31:0]  timer;
        logic [31:0]  timeout;
        reply_t       due_replies [$];
        int unsigned  errors;
        int unsigned  checked;
        int unsigned  status_seen [8];

        function new();
            stored  = 0;
            mode    = rfca_pkg::MODE_DISARMED;
            timer   = '0;
            timeout = rfca_pkg::TIMEOUT_RESET;
            errors  = 0;
            checked = 0;
            foreach (status_seen[i])
                status_seen[i] = 0;
        endfunction

        function void set_timeout(logic [31:0] value);
            timeout = value;
        endfunction

        function void note_request(request_t r);
            reply_t y;
            bit     found;
            y.status    = rfca_pkg::STS_OK;
            y.cmd_valid = 1'b0;
            y.cmd_level = rfca_pkg::MODE_DISARMED;
            y.siren_off = 1'b0;
            y.match     = '0;
            found       = 1'b0;
            case (r.req)
                rfca_pkg::REQ_CARD_READ:
                begin
                    if (mode == rfca_pkg::MODE_ENROLL)
                    begin
                        if (stored < DEPTH)
                        begin
                            codes[stored] = r.code;
                            stored++;
                            y.status = rfca_pkg::STS_ENROLLED;
                        end
                        else
                            y.status = rfca_pkg::STS_TABLE_FULL;
                        mode = rfca_pkg::MODE_DISARMED;
                    end
                    else
                    begin
                        for (int unsigned i = 0; i < stored && !found; i++)
                        begin
                            if (codes[i] == r.code)
                            begin
                                found   = 1'b1;
                                y.match = 4'(i);
                            end
                        end
                        if (found)
                        begin
                            y.status    = rfca_pkg::STS_GRANTED;
                            y.cmd_valid = 1'b1;
                            if (mode == rfca_pkg::MODE_DISARMED)
                            begin
                                y.cmd_level = rfca_pkg::MODE_ARMING;
                                y.siren_off = 1'b1;
                            end
                        end
                        else
                            y.status = rfca_pkg::STS_DENIED;
                    end
                end
                rfca_pkg::REQ_START_ENROLL:
                begin
                    if (mode != rfca_pkg::MODE_DISARMED)
                        y.status = rfca_pkg::STS_NOT_DISARMED;
                    else if (stored >= DEPTH)
                        y.status = rfca_pkg::STS_TABLE_FULL;
                    else
                    begin
                        mode  = rfca_pkg::MODE_ENROLL;
                        timer = '0;
                    end
                end
                rfca_pkg::REQ_REVOKE:
                begin
                    if (r.idx >= stored)
                        y.status = rfca_pkg::STS_BAD_INDEX;
                    else
                    begin
                        for (int unsigned i = r.idx; i + 1 < stored; i++)
                            codes[i] = codes[i + 1];
                        stored--;
                    end
                end
                rfca_pkg::REQ_TICK:
                begin
                    if (mode == rfca_pkg::MODE_ENROLL)
                    begin
                        if (timer != '1)
                            timer++;
                        if (timer >= timeout)
                        begin
                            mode     = rfca_pkg::MODE_DISARMED;
                            y.status = rfca_pkg::STS_TIMEOUT;
                        end
                    end
                end
                rfca_pkg::REQ_SET_STATE:
                begin
                    if (mode != rfca_pkg::MODE_ENROLL && r.lvl <= rfca_pkg::MODE_ALARM)
                        mode = r.lvl;
                end
                default:
                    ;
            endcase
            y.alarm = mode;
            y.count = 5'(stored);
            due_replies = {due_replies, y};
        endfunction

        function void check_field(string name, int unsigned want, int unsigned got);
            if (want != got)
            begin
                $error("%s mismatch: expected %0d, actual %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(logic [23:0] data, logic [2:0] user);
            reply_t y;
            status_seen[user]++;
            if (due_replies.size() == 0)
            begin
                $error("reply with status %0d arrived with no request pending", user);
                errors++;
                return;
            end
            y = due_replies.pop_front();
            checked++;
            check_field("status", y.status, user);
            check_field("alarm_state", y.alarm, data[2:0]);
            check_field("command_valid", y.cmd_valid, data[3]);
            check_field("command_state", y.cmd_level, data[6:4]);
            check_field("switch_off_alarm", y.siren_off, data[7]);
            check_field("entry_count", y.count, data[12:8]);
            check_field("matched_index", y.match, data[16:13]);
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;
    logic [2:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        cfg_wr_en;
    logic [31:0] cfg_wr_data;

    credential_scoreboard sb;
    bit          quiet;
    int unsigned issued;
    int unsigned settings;
    int unsigned stuck;

    rfid_credential_table_arming_control i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    always @(posedge clk)
        m_tready <= quiet || ($urandom_range(0, 99) >= 16);

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tuser);
    end

    initial
    begin
        stuck = 0;
        while (stuck < STUCK_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stuck = 0;
            else
                stuck++;
        end
        $display("FAIL rfid_credential_table_arming_control");
        $finish;
    end

    task automatic drive_request(request_t r);
        while (!quiet && $urandom_range(0, 99) < 16)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= r.req;
        s_tdata  <= {5'd0, r.lvl, r.idx, r.code};
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_request(r);
        issued++;
    endtask

    task automatic send(logic [2:0] req, logic [31:0] code, logic [7:0] idx, logic [2:0] lvl);
        request_t r;
        r.req  = req;
        r.code = code;
        r.idx  = idx;
        r.lvl  = lvl;
        drive_request(r);
    endtask

    task automatic set_enroll_timeout(logic [31:0] value);
        s_tvalid <= 1'b0;
        while (sb.due_replies.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        sb.set_timeout(value);
        settings++;
    endtask

    function automatic request_t random_request();
        request_t r;
        r.req  = 3'($urandom_range(0, 7));
        r.code = $urandom;
        r.idx  = 8'($urandom_range(0, 255));
        r.lvl  = 3'($urandom_range(0, 7));
        return r;
    endfunction

    function automatic logic [31:0] pick_code();
        if (sb.stored != 0 && $urandom_range(0, 99) < 60)
            return sb.codes[$urandom_range(0, sb.stored - 1)];
        return $urandom;
    endfunction

    task automatic run_random(int unsigned n, bit grow);
        request_t    r;
        int unsigned roll;
        int unsigned target;
        target = issued + n;
        while (issued < target)
        begin
            r    = random_request();
            roll = $urandom_range(0, 99);
            if (roll < 30)
            begin
                r.req  = rfca_pkg::REQ_CARD_READ;
                r.code = pick_code();
                drive_request(r);
            end
            else if (roll < (grow ? 52 : 42))
            begin
                r.req = rfca_pkg::REQ_START_ENROLL;
                drive_request(r);
                repeat ($urandom_range(0, 3))
                begin
                    r     = random_request();
                    r.req = rfca_pkg::REQ_TICK;
                    drive_request(r);
                end
                r      = random_request();
                r.req  = rfca_pkg::REQ_CARD_READ;
                r.code = ($urandom_range(0, 99) < 25) ? pick_code() : $urandom;
                drive_request(r);
            end
            else if (roll < (grow ? 57 : 62))
            begin
                r.req = rfca_pkg::REQ_REVOKE;
                if (sb.stored != 0 && $urandom_range(0, 99) < 80)
                    r.idx = 8'($urandom_range(0, sb.stored - 1));
                drive_request(r);
            end
            else if (roll < 74)
            begin
                r.req = rfca_pkg::REQ_TICK;
                drive_request(r);
            end
            else if (roll < 92)
            begin
                r.req = rfca_pkg::REQ_SET_STATE;
                if ($urandom_range(0, 1) == 0)
                    r.lvl = rfca_pkg::MODE_DISARMED;
                drive_request(r);
            end
            else if (roll < 96)
            begin
                r.req = 3'(rfca_pkg::REQ_SET_STATE) + 3'($urandom_range(1, 3));
                drive_request(r);
            end
            else
            begin
                r.req = rfca_pkg::REQ_START_ENROLL;
                drive_request(r);
            end
        end
    endtask

    initial
    begin
        sb          = new();
        quiet       = 1'b0;
        issued      = 0;
        settings    = 0;
        rst_n       <= 1'b0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        s_tuser     <= rfca_pkg::REQ_CARD_READ;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        set_enroll_timeout(32'd2);
        send(rfca_pkg::REQ_CARD_READ, 32'h0, 8'd0, rfca_pkg::MODE_DISARMED);
        send(rfca_pkg::REQ_REVOKE, 32'h0, 8'd0, rfca_pkg::MODE_DISARMED);
        send(rfca_pkg::REQ_TICK, 32'h0, 8'd0, rfca_pkg::MODE_DISARMED);
        send(3'(rfca_pkg::REQ_SET_STATE) + 3'd1, 32'h0, 8'd0, rfca_pkg::MODE_DISARMED);
        send(3'(rfca_pkg::REQ_SET_STATE) + 3'd3, 32'h0, 8'd0, rfca_pkg::MODE_DISARMED);
        send(rfca_pkg::REQ_START_ENROLL, 32'h0, 8'd0, rfca_pkg::MODE_DISARMED);
        send(rfca_pkg::REQ_START_ENROLL, 32'h0, 8'd0, rfca_pkg::MODE_DISARMED);
        send(rfca_pkg::REQ_SET_STATE, 32'h0, 8'd0, 3'd2);
        send(rfca_pkg::REQ_CARD_READ, 32'hFFFF_FFFF, 8'd0, rfca_pkg::MODE_DISARMED);
        send(rfca_pkg::REQ_START_ENROLL, 32'h0, 8'd0, rfca_pkg::MODE_DISARMED);
        send(rfca_pkg::REQ_CARD_READ, 32'h0, 8'd0, rfca_pkg::MODE_DISARMED);
        send(rfca_pkg::REQ_START_ENROLL, 32'h0, 8'd0, rfca_pkg::MODE_DISARMED);
        send(rfca_pkg::REQ_TICK, 32'h0, 8'd0, rfca_pkg::MODE_DISARMED);
        send(rfca_pkg::REQ_TICK, 32'h0, 8'd0, rfca_pkg::MODE_DISARMED);
        send(rfca_pkg::REQ_CARD_READ, 32'hFFFF_FFFF, 8'd0, rfca_pkg::MODE_DISARMED);
        send(rfca_pkg::REQ_SET_STATE, 32'h0, 8'd0, rfca_pkg::MODE_ALARM);
        send(rfca_pkg::REQ_CARD_READ, 32'h0, 8'd0, rfca_pkg::MODE_DISARMED);
        send(rfca_pkg::REQ_START_ENROLL, 32'h0, 8'd0, rfca_pkg::MODE_DISARMED);
        send(rfca_pkg::REQ_SET_STATE, 32'h0, 8'd0, rfca_pkg::MODE_ENROLL);
        send(rfca_pkg::REQ_SET_STATE, 32'h0, 8'd0, 3'(rfca_pkg::MODE_ENROLL) + 3'd1);
        send(rfca_pkg::REQ_CARD_READ, 32'h1234_5678, 8'd0, rfca_pkg::MODE_DISARMED);
        send(rfca_pkg::REQ_REVOKE, 32'h0, 8'd255, rfca_pkg::MODE_DISARMED);
        send(rfca_pkg::REQ_REVOKE, 32'h0, 8'd0, rfca_pkg::MODE_DISARMED);
        send(rfca_pkg::REQ_SET_STATE, 32'h0, 8'd0, rfca_pkg::MODE_DISARMED);
        send(rfca_pkg::REQ_CARD_READ, 32'h0, 8'd0, rfca_pkg::MODE_DISARMED);

        set_enroll_timeout(32'd3);
        run_random(150, 1'b1);
        set_enroll_timeout(32'd1);
        quiet = 1'b1;
        run_random(100, 1'b0);
        quiet = 1'b0;
        set_enroll_timeout(32'hFFFF_FFFF);
        run_random(150, 1'b1);
        set_enroll_timeout(32'($urandom_range(4, 9)));
        run_random(125, 1'b0);

        s_tvalid <= 1'b0;
        while (sb.due_replies.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);

        $display("Sent %0d requests under %0d timeout settings, %0d replies checked.",
                 issued, settings, sb.checked);
        $display("Replies ok/granted/denied/enrolled/busy/full/bad/timeout: %0d %0d %0d %0d %0d %0d %0d %0d",
                 sb.status_seen[rfca_pkg::STS_OK], sb.status_seen[rfca_pkg::STS_GRANTED],
                 sb.status_seen[rfca_pkg::STS_DENIED], sb.status_seen[rfca_pkg::STS_ENROLLED],
                 sb.status_seen[rfca_pkg::STS_NOT_DISARMED],
                 sb.status_seen[rfca_pkg::STS_TABLE_FULL],
                 sb.status_seen[rfca_pkg::STS_BAD_INDEX], sb.status_seen[rfca_pkg::STS_TIMEOUT]);
        if (sb.errors == 0 && sb.due_replies.size() == 0)
            $display("PASS rfid_credential_table_arming_control");
        else
            $display("FAIL rfid_credential_table_arming_control");
        $finish;
    end

endmodule
